/* src/pap_pkg.sv */
// Shared constants, types and helpers of the padded 2D pooling block.
package pap_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_KERNEL = 16;

    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int KIDX_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int KDIM_W = 5;
    localparam int PDIM_W = 9;
    localparam int AREA_W = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int SUM_W  = 16 + $clog2(MAX_KERNEL * MAX_KERNEL);
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int CRD_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_AVG   = 2'd1,
        OP_MAX   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_W     = 3'd0,
        REG_KERNEL_H     = 3'd1,
        REG_STRIDE_X     = 3'd2,
        REG_STRIDE_Y     = 3'd3,
        REG_PAD_X        = 3'd4,
        REG_PAD_Y        = 3'd5,
        REG_PLANE_WIDTH  = 3'd6,
        REG_PLANE_HEIGHT = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [KDIM_W-1:0] kw;
        logic [KDIM_W-1:0] kh;
        logic [4:0]        sx;
        logic [4:0]        sy;
        logic [3:0]        px;
        logic [3:0]        py;
        logic [PDIM_W-1:0] pw;
        logic [PDIM_W-1:0] ph;
    } cfg_t;

    typedef struct packed {
        logic                    is_write;
        logic                    is_avg;
        logic [ADDR_W-1:0]       addr;
        logic [15:0]             data;
        logic signed [CRD_W-1:0] x0;
        logic signed [CRD_W-1:0] y0;
    } q_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WALK,
        BK_DRAIN,
        BK_SETUP,
        BK_DIV
    } back_state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CRD_W-1:0] y,
                                                    input logic [CRD_W-1:0] x);
        cell_addr = ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
    endfunction

endpackage

/* src/pap_ram.sv */
// Generic simple dual-port RAM with registered read data.
module pap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/pap_queue.sv */
// Short queue of classified items between the front and back parts.
module pap_queue
    import pap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    input  logic     pop,
    output q_entry_t head,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/pap_front.sv */
// Front part: configuration registers, item acceptance and classification.
module pap_front
    import pap_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 start,
    input  logic                 q_full,
    input  logic [1:0]           op,
    input  logic [7:0]           col,
    input  logic [7:0]           row,
    input  logic signed [15:0]   sample,
    output logic                 push,
    output q_entry_t             push_data,
    output cfg_t                 cfg
);

    logic [4:0]        kw_reg, kh_reg, sx_reg, sy_reg;
    logic [3:0]        px_reg, py_reg;
    logic [PDIM_W-1:0] pw_reg, ph_reg;
    logic [12:0]       xprod, yprod;
    logic              in_plane;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_reg <= 5'd2;
            kh_reg <= 5'd2;
            sx_reg <= 5'd2;
            sy_reg <= 5'd2;
            px_reg <= 4'd0;
            py_reg <= 4'd0;
            pw_reg <= 9'd256;
            ph_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KERNEL_W:     kw_reg <= cfg_data[4:0];
                REG_KERNEL_H:     kh_reg <= cfg_data[4:0];
                REG_STRIDE_X:     sx_reg <= cfg_data[4:0];
                REG_STRIDE_Y:     sy_reg <= cfg_data[4:0];
                REG_PAD_X:        px_reg <= cfg_data[3:0];
                REG_PAD_Y:        py_reg <= cfg_data[3:0];
                REG_PLANE_WIDTH:  pw_reg <= cfg_data;
                REG_PLANE_HEIGHT: ph_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.kw = (kw_reg == '0) ? KDIM_W'(1) :
                 (int'(kw_reg) > MAX_KERNEL) ? KDIM_W'(MAX_KERNEL) : kw_reg;
        cfg.kh = (kh_reg == '0) ? KDIM_W'(1) :
                 (int'(kh_reg) > MAX_KERNEL) ? KDIM_W'(MAX_KERNEL) : kh_reg;
        cfg.sx = (sx_reg == '0) ? 5'd1 : sx_reg;
        cfg.sy = (sy_reg == '0) ? 5'd1 : sy_reg;
        cfg.px = px_reg;
        cfg.py = py_reg;
        cfg.pw = (pw_reg == '0) ? PDIM_W'(1) :
                 (int'(pw_reg) > MAX_WIDTH) ? PDIM_W'(MAX_WIDTH) : pw_reg;
        cfg.ph = (ph_reg == '0) ? PDIM_W'(1) :
                 (int'(ph_reg) > MAX_HEIGHT) ? PDIM_W'(MAX_HEIGHT) : ph_reg;
    end

    always_comb
    begin
        accept   = start && !q_full;
        in_plane = ({1'b0, col} < cfg.pw) && ({1'b0, row} < cfg.ph);
        xprod    = 13'(col) * 13'(cfg.sx);
        yprod    = 13'(row) * 13'(cfg.sy);

        push_data.is_write = (op == OP_WRITE);
        push_data.is_avg   = (op == OP_AVG);
        push_data.addr     = cell_addr(CRD_W'(row), CRD_W'(col));
        push_data.data     = sample;
        push_data.x0       = $signed(CRD_W'(xprod)) - $signed(CRD_W'(cfg.px));
        push_data.y0       = $signed(CRD_W'(yprod)) - $signed(CRD_W'(cfg.py));

        case (op_t'(op))
            OP_WRITE: push = accept && in_plane;
            OP_AVG:   push = accept;
            OP_MAX:   push = accept;
            default:  push = 1'b0;
        endcase
    end

endmodule

/* src/pap_back.sv */
// Back part: plane writes, window walk, accumulation, max tracking and area division.
module pap_back
    import pap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  q_entry_t           head,
    input  logic               q_empty,
    output logic               pop,
    output logic               result_valid,
    output logic signed [15:0] pooled,
    output logic               window_empty
);

    back_state_t             state_reg, state_next;
    logic                    is_avg_reg, is_avg_next;
    logic signed [CRD_W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic [KIDX_W-1:0]       kx_reg, kx_next, ky_reg, ky_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [15:0]      best_reg, best_next;
    logic                    any_reg, any_next;
    logic                    pend_reg, pend_next;
    logic                    neg_reg, neg_next;
    logic [AREA_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [DCNT_W-1:0]       cnt_reg, cnt_next;
    logic                    res_valid_reg, res_valid_next;
    logic signed [15:0]      pooled_reg, pooled_next;
    logic                    empty_reg, empty_next;

    logic signed [CRD_W-1:0] xc, yc;
    logic                    cell_in;
    logic                    last_cell;
    logic [AREA_W-1:0]       area;
    logic [AREA_W:0]         trial;
    logic                    qbit;
    logic                    we, re;
    logic [ADDR_W-1:0]       raddr;
    logic [15:0]             rdata;

    pap_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH * MAX_HEIGHT)
    ) u_plane (
        .clk   (clk),
        .we    (we),
        .waddr (head.addr),
        .wdata (head.data),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_avg_reg <= is_avg_next;
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        kx_reg     <= kx_next;
        ky_reg     <= ky_next;
        sum_reg    <= sum_next;
        best_reg   <= best_next;
        any_reg    <= any_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        pooled_reg <= pooled_next;
        empty_reg  <= empty_next;
    end

    always_comb
    begin
        xc = x0_reg + $signed(CRD_W'(kx_reg));
        yc = y0_reg + $signed(CRD_W'(ky_reg));
        cell_in = !xc[CRD_W-1] && !yc[CRD_W-1] &&
                  ($unsigned(xc) < CRD_W'(cfg.pw)) && ($unsigned(yc) < CRD_W'(cfg.ph));
        last_cell = (kx_reg == KIDX_W'(cfg.kw - 1'b1)) && (ky_reg == KIDX_W'(cfg.kh - 1'b1));
        raddr = cell_addr($unsigned(yc), $unsigned(xc));
        area  = AREA_W'(cfg.kw) * AREA_W'(cfg.kh);
        trial = {rem_reg, quo_reg[SUM_W-1]};
        qbit  = (trial >= (AREA_W+1)'(area));

        state_next     = state_reg;
        is_avg_next    = is_avg_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        kx_next        = kx_reg;
        ky_next        = ky_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        any_next       = any_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        pooled_next    = pooled_reg;
        empty_next     = empty_reg;
        res_valid_next = 1'b0;
        pend_next      = 1'b0;
        pop            = 1'b0;
        we             = 1'b0;
        re             = 1'b0;

        if (pend_reg)
        begin
            sum_next = sum_reg + {{(SUM_W-16){rdata[15]}}, rdata};
            any_next = 1'b1;
            if ($signed(rdata) > best_reg)
            begin
                best_next = $signed(rdata);
            end
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (head.is_write)
                    begin
                        we = 1'b1;
                    end
                    else
                    begin
                        is_avg_next = head.is_avg;
                        x0_next     = head.x0;
                        y0_next     = head.y0;
                        kx_next     = '0;
                        ky_next     = '0;
                        sum_next    = '0;
                        best_next   = 16'sh8000;
                        any_next    = 1'b0;
                        state_next  = BK_WALK;
                    end
                end
            end
            BK_WALK:
            begin
                re        = cell_in;
                pend_next = cell_in;
                if (kx_reg == KIDX_W'(cfg.kw - 1'b1))
                begin
                    kx_next = '0;
                    ky_next = ky_reg + 1'b1;
                end
                else
                begin
                    kx_next = kx_reg + 1'b1;
                end
                if (last_cell)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_SETUP;
            end
            BK_SETUP:
            begin
                if (is_avg_reg)
                begin
                    neg_next   = sum_reg[SUM_W-1];
                    quo_next   = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = BK_DIV;
                end
                else
                begin
                    pooled_next    = best_reg;
                    empty_next     = !any_reg;
                    res_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            BK_DIV:
            begin
                rem_next = qbit ? AREA_W'(trial - (AREA_W+1)'(area)) : AREA_W'(trial);
                quo_next = {quo_reg[SUM_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(SUM_W - 1))
                begin
                    pooled_next    = neg_reg ? -$signed(quo_next[15:0])
                                             : $signed(quo_next[15:0]);
                    empty_next     = !any_reg;
                    res_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign pooled       = pooled_reg;
    assign window_empty = empty_reg;

endmodule

/* src/pool_2d_avg_max_padded.sv */
// Top level of the padded 2D average and max pooling block.
// The block holds one plane of signed Q8.8 samples in an on-chip memory.
// Configuration is written over cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, so each write is one transfer.
// An item transfers when start is high and busy is low. Op write stores
// sample at (col,row); op average or max returns one result for the window
// of output position (col,row). Writes outside the plane and the unused op
// code produce nothing. Accepted items wait in a two-entry queue, so busy
// rises only when that queue is full.
// The back end stores a write as it pops it. A query walks all kernel_w times
// kernel_h window cells, one cell per cycle with a memory read for each cell
// inside the plane, then drains the last read; max results follow at once,
// average results after a restoring division of the sum by the area.
// Each result is shown for exactly one cycle with result_valid high; the
// receiver cannot stall the block. Reset clears the queue and the control
// state and restores the register defaults; plane contents are undefined
// until written.
module pool_2d_avg_max_padded
    import pap_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           op,
    input  logic [7:0]           col,
    input  logic [7:0]           row,
    input  logic signed [15:0]   sample,
    output logic                 result_valid,
    output logic signed [15:0]   pooled,
    output logic                 window_empty
);

    cfg_t     cfg;
    q_entry_t push_data, head;
    logic     push, pop, q_full, q_empty;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;

    pap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .q_full    (q_full),
        .op        (op),
        .col       (col),
        .row       (row),
        .sample    (sample),
        .push      (push),
        .push_data (push_data),
        .cfg       (cfg)
    );

    pap_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    pap_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .pooled       (pooled),
        .window_empty (window_empty)
    );

endmodule

/* src/pap_checker.sv */
// Port-level checker for the pooling block, bound to the top level.
module pap_checker
    import pap_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_ready,
    input logic               busy,
    input logic               result_valid,
    input logic signed [15:0] pooled,
    input logic               window_empty
);

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready dropped");

    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results on consecutive cycles");

    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && window_empty) |-> (pooled == 16'sd0 || pooled == -16'sd32768))
        else $error("empty window with unexpected value");

    a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !busy)
        else $error("busy right after reset");

endmodule

bind pool_2d_avg_max_padded pap_checker u_pap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .busy         (busy),
    .result_valid (result_valid),
    .pooled       (pooled),
    .window_empty (window_empty)
);
